// ----- hdl/clr_pkg.sv -----
`default_nettype none

package clr_pkg;

  // Field widths of the line command and the pixel write.
  localparam int COORD_W = 12;
  localparam int COLOR_W = 16;
  localparam int POS_W   = 6;

  // Error term: wide enough for the sum or difference of two spans.
  localparam int SPAN_W  = COORD_W + 1;
  localparam int ERR_W   = SPAN_W + 2;

  // Guard on the number of non-final pixel writes per line.
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = 6;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [COLOR_W-1:0] color_t;
  typedef logic        [POS_W-1:0]   pos_t;
  typedef logic        [SPAN_W-1:0]  span_t;
  typedef logic signed [ERR_W-1:0]   err_t;
  typedef logic        [CNT_W-1:0]   cnt_t;

  localparam cnt_t CNT_MAX = cnt_t'(MAX_RESULTS - 1);

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic advance;
    logic emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;
    logic wants_emit;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- hdl/clr_if.sv -----
`default_nettype none

// Line command channel.
interface clr_in_if;
  logic            valid;
  logic            ready;
  clr_pkg::coord_t start_x;
  clr_pkg::coord_t start_y;
  clr_pkg::coord_t end_x;
  clr_pkg::coord_t end_y;
  clr_pkg::color_t pixel_color;

  modport source (
    output valid, start_x, start_y, end_x, end_y, pixel_color,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, end_x, end_y, pixel_color,
    output ready
  );
endinterface

// Pixel write channel.
interface clr_out_if;
  logic            valid;
  logic            ready;
  clr_pkg::pos_t   column;
  clr_pkg::pos_t   row;
  clr_pkg::color_t pixel_word;
  logic            visible;
  logic            last;

  modport source (
    output valid, column, row, pixel_word, visible, last,
    input  ready
  );
  modport sink (
    input  valid, column, row, pixel_word, visible, last,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/clr_datapath.sv -----
`default_nettype none

module clr_datapath #(
  parameter int WINDOW_WIDTH  = 32,
  parameter int WINDOW_HEIGHT = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire clr_pkg::coord_t     start_x,
  input  wire clr_pkg::coord_t     start_y,
  input  wire clr_pkg::coord_t     end_x,
  input  wire clr_pkg::coord_t     end_y,
  input  wire clr_pkg::color_t     pixel_color,
  input  wire clr_pkg::dp_cmd_t    cmd,
  output clr_pkg::dp_status_t      status,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output clr_pkg::pos_t            column,
  output clr_pkg::pos_t            row,
  output clr_pkg::color_t          pixel_word,
  output logic                     visible,
  output logic                     last
);
  import clr_pkg::*;

  // Walk state.
  coord_t x_r, x_nxt;
  coord_t y_r, y_nxt;
  coord_t xe_r, ye_r;
  span_t  dx_r, dy_r;
  logic   sx_neg_r, sy_neg_r;
  err_t   err_r, err_nxt;
  color_t word_r;
  cnt_t   cnt_r;

  // Output register.
  logic   out_valid_r;
  pos_t   column_r, row_r;
  color_t pixel_word_r;
  logic   visible_r, last_r;

  // Span and direction of each axis at load time.
  logic signed [SPAN_W-1:0] diff_x, diff_y;
  logic                     x_fwd, y_fwd;
  span_t                    dx_ld, dy_ld;
  err_t                     err_ld;

  assign diff_x = $signed({end_x[COORD_W-1], end_x}) - $signed({start_x[COORD_W-1], start_x});
  assign diff_y = $signed({end_y[COORD_W-1], end_y}) - $signed({start_y[COORD_W-1], start_y});
  assign x_fwd  = !diff_x[SPAN_W-1] && (diff_x != '0);
  assign y_fwd  = !diff_y[SPAN_W-1] && (diff_y != '0);
  assign dx_ld  = x_fwd ? span_t'(diff_x) : span_t'(-diff_x);
  assign dy_ld  = y_fwd ? span_t'(diff_y) : span_t'(-diff_y);
  assign err_ld = $signed({2'b00, dx_ld}) - $signed({2'b00, dy_ld});

  // One Bresenham step from the current point.
  logic signed [ERR_W:0] e2, dx_cmp, dy_cmp;
  logic                  step_x, step_y;
  err_t                  dx_err, dy_err;

  assign e2     = {err_r, 1'b0};
  assign dx_cmp = $signed({3'b000, dx_r});
  assign dy_cmp = $signed({3'b000, dy_r});
  assign step_x = e2 > -dy_cmp;
  assign step_y = e2 < dx_cmp;
  assign dx_err = $signed({2'b00, dx_r});
  assign dy_err = $signed({2'b00, dy_r});

  always_comb begin
    err_nxt = err_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    if (step_x) begin
      err_nxt = err_nxt - dy_err;
      x_nxt   = x_r + (sx_neg_r ? coord_t'(-1) : coord_t'(1));
    end
    if (step_y) begin
      err_nxt = err_nxt + dx_err;
      y_nxt   = y_r + (sy_neg_r ? coord_t'(-1) : coord_t'(1));
    end
  end

  // Window test and end detection for the current point.
  logic in_window, done;

  assign in_window = !x_r[COORD_W-1] && (x_r[COORD_W-2:0] < (COORD_W-1)'(WINDOW_WIDTH)) &&
                     !y_r[COORD_W-1] && (y_r[COORD_W-2:0] < (COORD_W-1)'(WINDOW_HEIGHT));
  assign done      = (x_r == xe_r) && (y_r == ye_r);

  assign status.done       = done;
  assign status.wants_emit = done || (in_window && (cnt_r < CNT_MAX));
  assign status.out_free   = !out_valid_r || out_ready;

  // Walk registers: loaded from the command, then stepped.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r      <= start_x;
      y_r      <= start_y;
      xe_r     <= end_x;
      ye_r     <= end_y;
      dx_r     <= dx_ld;
      dy_r     <= dy_ld;
      sx_neg_r <= !x_fwd;
      sy_neg_r <= !y_fwd;
      err_r    <= err_ld;
      word_r   <= {pixel_color[7:0], pixel_color[15:8]};
    end else if (cmd.advance) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      err_r <= err_nxt;
    end
  end

  // Count of non-final writes for the result guard.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= '0;
    end else if (cmd.emit && !done) begin
      cnt_r <= cnt_r + cnt_t'(1);
    end
  end

  // Output valid flag: set on a new write, cleared when the transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload; a clipped final point carries zero fields.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      column_r     <= in_window ? x_r[POS_W-1:0] : '0;
      row_r        <= in_window ? y_r[POS_W-1:0] : '0;
      pixel_word_r <= in_window ? word_r : '0;
      visible_r    <= in_window;
      last_r       <= done;
    end
  end

  assign out_valid  = out_valid_r;
  assign column     = column_r;
  assign row        = row_r;
  assign pixel_word = pixel_word_r;
  assign visible    = visible_r;
  assign last       = last_r;

endmodule

`default_nettype wire

// ----- hdl/clr_ctrl.sv -----
`default_nettype none

module clr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire clr_pkg::dp_status_t status,
  output clr_pkg::dp_cmd_t         cmd,
  output clr_pkg::state_t          state
);
  import clr_pkg::*;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.advance = 1'b0;
    cmd.emit    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        // A point that writes nothing steps on even while the output is full.
        if (!status.wants_emit || status.out_free) begin
          cmd.emit    = status.wants_emit;
          cmd.advance = !status.done;
          if (status.done) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign state = state_r;

endmodule

`default_nettype wire

// ----- hdl/clipped_line_rasterizer_core.sv -----
// Clipped line rasterizer.
// The in_chan channel takes one line command per transfer: two signed 12-bit
// endpoints and an RGB565 color. The out_chan channel gives one pixel write
// per transfer: window column, row, the byte-swapped color, a visible flag
// and a last flag. Every line ends with exactly one write marked last; when
// the end point lies outside the window that write has visible low and zero
// column, row and color.
// A command is taken only while no line is being walked. The transfer loads
// it into the walk registers, then the walk advances one point per cycle
// unless a write waits on a stalled receiver: one point per cycle is the rate
// of the single error-term update unit. The first write passes through the
// walk registers and then the output register.
// The writes leave through an output register. When the receiver stalls,
// the walk holds on the next point that writes (a visible one or the end
// point); other points keep stepping. The next command is taken while the
// final write still waits. Reset clears the controller, the write counter
// and the output valid flag; no memory needs clearing.
`default_nettype none

module clipped_line_rasterizer_core #(
  parameter int WINDOW_WIDTH  = 32,
  parameter int WINDOW_HEIGHT = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  clr_in_if.sink    in_chan,
  clr_out_if.source out_chan
);
  import clr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  state_t     state;

  clr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .status   (status),
    .cmd      (cmd),
    .state    (state)
  );

  clr_datapath #(
    .WINDOW_WIDTH  (WINDOW_WIDTH),
    .WINDOW_HEIGHT (WINDOW_HEIGHT)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_x     (in_chan.start_x),
    .start_y     (in_chan.start_y),
    .end_x       (in_chan.end_x),
    .end_y       (in_chan.end_y),
    .pixel_color (in_chan.pixel_color),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .column      (out_chan.column),
    .row         (out_chan.row),
    .pixel_word  (out_chan.pixel_word),
    .visible     (out_chan.visible),
    .last        (out_chan.last)
  );

  // No pixel write is issued while the controller waits for a command.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state == ST_IDLE) |-> !cmd.emit && !cmd.advance)
    else $error("write or step issued while idle");

  // The final write of a line returns the controller to idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && status.done) |=> (state == ST_IDLE))
    else $error("controller did not return to idle after the final write");

  // The walk never steps past the end point.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |-> !status.done)
    else $error("walk stepped past the end point");

  // A visible write always lies inside the window.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.visible) |->
      (out_chan.column < POS_W'(WINDOW_WIDTH)) && (out_chan.row < POS_W'(WINDOW_HEIGHT)))
    else $error("visible write outside the window");

endmodule

`default_nettype wire

// ----- tb/sv/tb_clipped_line_rasterizer_core.sv -----
`timescale 1ns / 100ps

module tb_clipped_line_rasterizer_core;
  import clr_pkg::*;

  localparam int WIN_W        = 32;
  localparam int WIN_H        = 32;
  localparam int CYCLE_LIMIT  = 10_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;

  // One line command as it travels on the input channel.
  typedef struct {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t pixel_color;
  } line_cmd_t;

  // One frame-buffer write as it leaves the block.
  typedef struct {
    pos_t   column;
    pos_t   row;
    color_t pixel_word;
    logic   visible;
    logic   last;
  } pixel_write_t;

  typedef enum {
    SHAPE_NEAR,
    SHAPE_POINT,
    SHAPE_FLAT,
    SHAPE_FAR_END,
    SHAPE_FULL_RANGE
  } line_shape_t;

  logic clk = 1'b0;
  logic rst_n;

  clr_in_if  line_bus ();
  clr_out_if pixel_bus ();

  pixel_write_t pending_pixels[$];
  int           mismatch_count = 0;
  int           cycle_count    = 0;
  int           send_idle_pct  = 0;
  int           recv_idle_pct  = 0;
  int           stall_request  = 0;
  int           stall_left     = 0;

  clipped_line_rasterizer_core #(
    .WINDOW_WIDTH (WIN_W),
    .WINDOW_HEIGHT(WIN_H)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (line_bus),
    .out_chan(pixel_bus)
  );

  always #1 clk = ~clk;

  // Walk the error term of one line and queue every write it should produce.
  function automatic void rasterize_line(input coord_t x0, input coord_t y0,
                                         input coord_t x1, input coord_t y1,
                                         input color_t color);
    int           x;
    int           y;
    int           xe;
    int           ye;
    int           dx;
    int           dy;
    int           step_x;
    int           step_y;
    int           err;
    int           e2;
    int           writes;
    bit           in_window;
    color_t       swapped;
    pixel_write_t w;
    x       = x0;
    y       = y0;
    xe      = x1;
    ye      = y1;
    swapped = {color[7:0], color[15:8]};
    dx      = (x < xe) ? xe - x : x - xe;
    dy      = (y < ye) ? ye - y : y - ye;
    step_x  = (x < xe) ? 1 : -1;
    step_y  = (y < ye) ? 1 : -1;
    err     = dx - dy;
    writes  = 0;
    forever begin
      in_window = (x >= 0) && (x < WIN_W) && (y >= 0) && (y < WIN_H);
      // The end point always gives the closing write, blanked when clipped.
      if (x == xe && y == ye) begin
        w.column     = in_window ? pos_t'(x) : '0;
        w.row        = in_window ? pos_t'(y) : '0;
        w.pixel_word = in_window ? swapped : '0;
        w.visible    = in_window;
        w.last       = 1'b1;
        pending_pixels.push_back(w);
        break;
      end
      if (in_window && writes < MAX_RESULTS - 1) begin
        w.column     = pos_t'(x);
        w.row        = pos_t'(y);
        w.pixel_word = swapped;
        w.visible    = 1'b1;
        w.last       = 1'b0;
        pending_pixels.push_back(w);
        writes++;
      end
      e2 = 2 * err;
      if (e2 > -dy) begin
        err -= dy;
        x   += step_x;
      end
      if (e2 < dx) begin
        err += dx;
        y   += step_y;
      end
    end
  endfunction

  // Predict on every command transfer.
  always @(posedge clk) begin
    if (rst_n && line_bus.valid && line_bus.ready) begin
      rasterize_line(line_bus.start_x, line_bus.start_y, line_bus.end_x, line_bus.end_y,
                     line_bus.pixel_color);
    end
  end

  // Compare each pixel write transfer with the oldest expected write.
  always @(posedge clk) begin
    pixel_write_t want;
    if (rst_n && pixel_bus.valid && pixel_bus.ready) begin
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("Unexpected write: col=%0d row=%0d word=%h vis=%b last=%b",
                   pixel_bus.column, pixel_bus.row, pixel_bus.pixel_word,
                   pixel_bus.visible, pixel_bus.last);
        end
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_bus.column !== want.column || pixel_bus.row !== want.row ||
            pixel_bus.pixel_word !== want.pixel_word ||
            pixel_bus.visible !== want.visible || pixel_bus.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("Write mismatch: expected col=%0d row=%0d word=%h vis=%b last=%b",
                     want.column, want.row, want.pixel_word, want.visible, want.last);
            $display("                actual   col=%0d row=%0d word=%h vis=%b last=%b",
                     pixel_bus.column, pixel_bus.row, pixel_bus.pixel_word,
                     pixel_bus.visible, pixel_bus.last);
          end
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (stall_request > 0) begin
      stall_left    = stall_request;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      pixel_bus.ready <= 1'b0;
      stall_left--;
    end else begin
      pixel_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one command, after a random gap, and wait for its transfer.
  // Valid stays high afterwards so back-to-back commands need no extra edge.
  task automatic send_line(input line_cmd_t cmd);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      line_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    line_bus.valid       <= 1'b1;
    line_bus.start_x     <= cmd.start_x;
    line_bus.start_y     <= cmd.start_y;
    line_bus.end_x       <= cmd.end_x;
    line_bus.end_y       <= cmd.end_y;
    line_bus.pixel_color <= cmd.pixel_color;
    @(posedge clk);
    while (!line_bus.ready) @(posedge clk);
  endtask

  task automatic send_coords(input int x0, input int y0, input int x1, input int y1,
                             input color_t color);
    line_cmd_t cmd;
    cmd.start_x     = coord_t'(x0);
    cmd.start_y     = coord_t'(y0);
    cmd.end_x       = coord_t'(x1);
    cmd.end_y       = coord_t'(y1);
    cmd.pixel_color = color;
    send_line(cmd);
  endtask

  // A coordinate a little around the window, so lines cross its edges often.
  function automatic coord_t near_coord();
    return coord_t'($urandom_range(71) - 20);
  endfunction

  // Mostly short lines around the window; a few long ones span the whole range.
  task automatic send_random_lines(input int count);
    line_cmd_t   cmd;
    line_shape_t shape;
    int          pick;
    repeat (count) begin
      pick  = $urandom_range(99);
      shape = (pick < 4)  ? SHAPE_FULL_RANGE :
              (pick < 10) ? SHAPE_FAR_END :
              (pick < 18) ? SHAPE_POINT :
              (pick < 28) ? SHAPE_FLAT : SHAPE_NEAR;
      cmd.start_x     = near_coord();
      cmd.start_y     = near_coord();
      cmd.end_x       = near_coord();
      cmd.end_y       = near_coord();
      cmd.pixel_color = color_t'($urandom);
      unique case (shape)
        SHAPE_POINT: begin
          cmd.end_x = cmd.start_x;
          cmd.end_y = cmd.start_y;
        end
        SHAPE_FLAT: begin
          if ($urandom_range(1)) cmd.end_y = cmd.start_y;
          else cmd.end_x = cmd.start_x;
        end
        SHAPE_FAR_END: begin
          if ($urandom_range(1)) cmd.end_x = coord_t'($urandom_range(4095));
          else cmd.start_y = coord_t'($urandom_range(4095));
        end
        SHAPE_FULL_RANGE: begin
          cmd.start_x = coord_t'($urandom_range(4095));
          cmd.start_y = coord_t'($urandom_range(4095));
          cmd.end_x   = coord_t'($urandom_range(4095));
          cmd.end_y   = coord_t'($urandom_range(4095));
        end
        default: ;
      endcase
      send_line(cmd);
    end
  endtask

  // Edges of the window, single points, clipped ends and coordinate extremes.
  task automatic test_directed_lines();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_coords(5, 7, 5, 7, 16'h1234);
    send_coords(-1, -1, -1, -1, 16'hFFFF);
    send_coords(31, 31, 31, 31, 16'h00FF);
    send_coords(32, 0, 32, 0, 16'hFF00);
    send_coords(0, 32, 0, 32, 16'hA55A);
    send_coords(0, 0, 31, 0, 16'h0000);
    send_coords(31, 31, 31, 0, 16'hFFFF);
    send_coords(0, 31, 31, 0, 16'h5AA5);
    send_coords(3, 2, 10, 29, 16'h8001);
    send_coords(29, 3, 2, 10, 16'h7FFE);
    send_coords(-10, 5, 40, 20, 16'hC3C3);
    send_coords(-5, -5, 10, 10, 16'h3C3C);
    send_coords(100, 100, 200, 150, 16'h0F0F);
    send_coords(40, 16, -8, 16, 16'hF0F0);
    send_coords(16, -8, 16, 40, 16'h1357);
    send_coords(-2048, -2048, 2047, 2047, 16'h2468);
    send_coords(2047, -2048, -2048, 2047, 16'hFEDC);
    send_coords(-2048, 2047, -2048, 2047, 16'hBA98);
    send_coords(2047, 2047, 2047, -2048, 16'h0001);
    send_coords(-2048, 10, 20, 12, 16'h8000);
    send_coords(10, 2047, 12, 0, 16'h4321);
  endtask

  task automatic test_random_slow_receiver();
    send_idle_pct = 25;
    recv_idle_pct = 73;
    send_random_lines(110);
  endtask

  task automatic test_random_slow_sender();
    send_idle_pct = 73;
    recv_idle_pct = 25;
    send_random_lines(110);
  endtask

  task automatic test_random_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_lines(110);
  endtask

  // Hold the receiver off long enough that the block stalls its input.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 400;
    send_random_lines(20);
  endtask

  initial begin
    rst_n                = 1'b0;
    line_bus.valid       = 1'b0;
    line_bus.start_x     = '0;
    line_bus.start_y     = '0;
    line_bus.end_x       = '0;
    line_bus.end_y       = '0;
    line_bus.pixel_color = '0;
    pixel_bus.ready      = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_lines();
    test_random_slow_receiver();
    test_random_slow_sender();
    test_random_full_rate();
    test_output_backpressure();
    line_bus.valid <= 1'b0;

    // Let every expected write arrive, then watch for stray ones.
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/clr_pkg.sv
hdl/clr_if.sv
hdl/clr_datapath.sv
hdl/clr_ctrl.sv
hdl/clipped_line_rasterizer_core.sv
tb/sv/tb_clipped_line_rasterizer_core.sv
